/* src/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared codes, operation encodings and the queue item type.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 256;
    localparam int QUEUE_AW             = 1;
    localparam int QUEUE_DEPTH          = 1 << QUEUE_AW;

    // Input item kinds.
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_LOAD   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Master status codes of the byte engine.
    localparam logic [7:0] SC_START        = 8'h08;
    localparam logic [7:0] SC_RESTART      = 8'h10;
    localparam logic [7:0] SC_SLAW_ACK     = 8'h18;
    localparam logic [7:0] SC_SLAW_NACK    = 8'h20;
    localparam logic [7:0] SC_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] SC_DATA_TX_NACK = 8'h30;
    localparam logic [7:0] SC_ARB_LOST     = 8'h38;
    localparam logic [7:0] SC_SLAR_ACK     = 8'h40;
    localparam logic [7:0] SC_SLAR_NACK    = 8'h48;
    localparam logic [7:0] SC_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] SC_DATA_RX_NACK = 8'h58;

    // Classified operations handed from the front to the back.
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_START     = 4'd1;
    localparam logic [3:0] OP_LOAD      = 4'd2;
    localparam logic [3:0] OP_ADDR      = 4'd3;
    localparam logic [3:0] OP_TX_FIRST  = 4'd4;
    localparam logic [3:0] OP_ABORT     = 4'd5;
    localparam logic [3:0] OP_TX_NEXT   = 4'd6;
    localparam logic [3:0] OP_ARB_LOST  = 4'd7;
    localparam logic [3:0] OP_RX_ARM    = 4'd8;
    localparam logic [3:0] OP_RX_DATA   = 4'd9;
    localparam logic [3:0] OP_RX_LAST   = 4'd10;
    localparam logic [3:0] OP_UNKNOWN   = 4'd11;

    // Control field codes.
    localparam logic [1:0] CTL_NONE = 2'd0;
    localparam logic [1:0] CTL_SET  = 2'd1;
    localparam logic [1:0] CTL_CLR  = 2'd2;

    // Transfer status codes.
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_READ_NOT_WRITE  = 2'd1;
    localparam logic [1:0] REG_TRANSFER_LENGTH = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] data;
        logic [7:0] pos;
    } t_op_item;

endpackage

/* src/i2cms_if.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer channels
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] status_code;
    logic [7:0] rx_data;
    logic [7:0] load_index;
    logic [7:0] load_byte;

    modport source (
        output valid, kind, status_code, rx_data, load_index, load_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, status_code, rx_data, load_index, load_byte,
        output ready
    );
endinterface

interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] start_ctl;
    logic       stop_set;
    logic [1:0] ack_ctl;
    logic       irq_clear;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       done_res;
    logic [1:0] xfer_status;

    modport source (
        output valid, start_ctl, stop_set, ack_ctl, irq_clear, tx_valid, tx_byte,
               rx_valid, rx_byte, rx_index, done_res, xfer_status,
        input  ready
    );
    modport sink (
        input  valid, start_ctl, stop_set, ack_ctl, irq_clear, tx_valid, tx_byte,
               rx_valid, rx_byte, rx_index, done_res, xfer_status,
        output ready
    );
endinterface

interface i2cms_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* src/i2c_master_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Drives one I2C master read or write transfer from the status codes of a
// byte-level I2C engine and returns one result beat per input beat.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle while its queue is not full and
// returns one result beat for each, in order. A beat is classified in the
// cycle it is accepted, waits in a two-entry queue, and is executed by the
// back end, whose output register holds the result; the transfer buffer has a
// single write port and a single registered read port. Buffer entries are
// undefined until loaded or received, and there is no clearing pass after
// reset. Configuration registers may be written only while no beat is in
// flight.
module i2c_master_transfer_sequencer import i2cms_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cms_in_if.sink    i_in,
    i2cms_cfg_if.sink   i_cfg,
    i2cms_out_if.source o_out
);

    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    t_op_item push_item;
    t_op_item head_item;

    i2cms_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    i2cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_item)
    );

    i2cms_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_item),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

/* src/i2cms_front.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer front end
// Accepts input beats and classifies them into operations for the queue.
// ----------------------------------------------------------------------------
module i2cms_front import i2cms_pkg::*; (
    i2cms_in_if.sink i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_op_item o_item
);

    logic [3:0] event_op;
    logic [3:0] op;

    always_comb begin
        case (i_in.status_code)
            SC_START, SC_RESTART:                        event_op = OP_ADDR;
            SC_SLAW_ACK:                                 event_op = OP_TX_FIRST;
            SC_SLAW_NACK, SC_DATA_TX_NACK, SC_SLAR_NACK: event_op = OP_ABORT;
            SC_DATA_TX_ACK:                              event_op = OP_TX_NEXT;
            SC_ARB_LOST:                                 event_op = OP_ARB_LOST;
            SC_SLAR_ACK:                                 event_op = OP_RX_ARM;
            SC_DATA_RX_ACK:                              event_op = OP_RX_DATA;
            SC_DATA_RX_NACK:                             event_op = OP_RX_LAST;
            default:                                     event_op = OP_UNKNOWN;
        endcase
    end

    always_comb begin
        case (i_in.kind)
            KIND_START:  op = OP_START;
            KIND_EVENT:  op = event_op;
            KIND_LOAD:   op = OP_LOAD;
            KIND_UNUSED: op = OP_NOP;
            default:     op = OP_NOP;
        endcase
    end

    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;
    assign o_item.op   = op;
    assign o_item.data = (i_in.kind == KIND_LOAD) ? i_in.load_byte : i_in.rx_data;
    assign o_item.pos  = i_in.load_index;

endmodule

/* src/i2cms_queue.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module i2cms_queue import i2cms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_op_item i_item,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_op_item o_head
);

    t_op_item              r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/i2cms_back.sv */
// ----------------------------------------------------------------------------
// I2C master transfer sequencer back end
// Executes queued operations, keeps the transfer state and buffer, and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module i2cms_back import i2cms_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_op_item    i_head,
    output logic        o_pop,
    i2cms_cfg_if.sink   i_cfg,
    i2cms_out_if.source o_out
);

    localparam int         AW      = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    logic [6:0] r_target_address;
    logic       r_read_not_write;
    logic [7:0] r_transfer_length;
    logic [7:0] r_byte_index;
    logic [1:0] r_status;

    logic       r_out_valid;
    logic [1:0] r_start_ctl;
    logic       r_stop_set;
    logic [1:0] r_ack_ctl;
    logic       r_irq_clear;
    logic       r_tx_valid;
    logic       r_tx_from_mem;
    logic [7:0] r_tx_byte;
    logic       r_rx_valid;
    logic [7:0] r_rx_byte;
    logic [7:0] r_rx_index;
    logic       r_done_res;

    logic [7:0] n_byte_index;
    logic [1:0] n_status;
    logic [1:0] start_ctl;
    logic       stop_set;
    logic [1:0] ack_ctl;
    logic       irq_clear;
    logic       tx_valid;
    logic       tx_from_mem;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       done_res;
    logic       wr_req;
    logic [7:0] wr_pos;
    logic [7:0] wr_data;
    logic       rd_req;
    logic [7:0] rd_pos;
    logic [7:0] index_inc;
    logic       mem_we;
    logic       mem_re;

    function automatic logic in_buffer(input logic [7:0] pos);
        in_buffer = ({1'b0, pos} < DEPTH_W);
    endfunction

    function automatic logic [1:0] ack_choice(input logic [7:0] idx, input logic [7:0] len);
        ack_choice = (({1'b0, idx} + 9'd1) >= {1'b0, len}) ? CTL_CLR : CTL_SET;
    endfunction

    assign o_pop     = !i_empty && (!r_out_valid || o_out.ready);
    assign index_inc = r_byte_index + 8'd1;

    always_comb begin
        n_byte_index = r_byte_index;
        n_status     = r_status;
        start_ctl    = CTL_NONE;
        stop_set     = 1'b0;
        ack_ctl      = CTL_NONE;
        irq_clear    = 1'b0;
        tx_valid     = 1'b0;
        tx_from_mem  = 1'b0;
        tx_byte      = 8'd0;
        rx_valid     = 1'b0;
        rx_byte      = 8'd0;
        rx_index     = 8'd0;
        done_res     = 1'b0;
        wr_req       = 1'b0;
        wr_pos       = i_head.pos;
        wr_data      = i_head.data;
        rd_req       = 1'b0;
        rd_pos       = r_byte_index;

        case (i_head.op)
            OP_START: begin
                n_byte_index = 8'd0;
                n_status     = ST_BUSY;
                start_ctl    = CTL_SET;
            end
            OP_LOAD: begin
                wr_req = 1'b1;
            end
            OP_ADDR: begin
                irq_clear    = 1'b1;
                tx_valid     = 1'b1;
                tx_byte      = {r_target_address, r_read_not_write};
                start_ctl    = CTL_CLR;
                n_byte_index = 8'd0;
            end
            OP_TX_FIRST: begin
                irq_clear   = 1'b1;
                start_ctl   = CTL_CLR;
                tx_valid    = 1'b1;
                rd_pos      = r_byte_index;
                rd_req      = in_buffer(r_byte_index);
                tx_from_mem = in_buffer(r_byte_index);
            end
            OP_ABORT: begin
                irq_clear = 1'b1;
                start_ctl = CTL_CLR;
                n_status  = ST_ERR;
                done_res  = 1'b1;
                stop_set  = 1'b1;
            end
            OP_TX_NEXT: begin
                irq_clear    = 1'b1;
                start_ctl    = CTL_CLR;
                n_byte_index = index_inc;
                if (index_inc >= r_transfer_length) begin
                    n_status = ST_OK;
                    done_res = 1'b1;
                    stop_set = 1'b1;
                end else begin
                    tx_valid    = 1'b1;
                    rd_pos      = index_inc;
                    rd_req      = in_buffer(index_inc);
                    tx_from_mem = in_buffer(index_inc);
                end
            end
            OP_ARB_LOST: begin
                irq_clear = 1'b1;
                start_ctl = CTL_SET;
            end
            OP_RX_ARM: begin
                irq_clear = 1'b1;
                start_ctl = CTL_CLR;
                ack_ctl   = ack_choice(r_byte_index, r_transfer_length);
            end
            OP_RX_DATA, OP_RX_LAST: begin
                irq_clear = 1'b1;
                start_ctl = CTL_CLR;
                if (r_byte_index < r_transfer_length) begin
                    rx_valid     = 1'b1;
                    rx_byte      = i_head.data;
                    rx_index     = r_byte_index;
                    wr_req       = 1'b1;
                    wr_pos       = r_byte_index;
                    n_byte_index = index_inc;
                end
                if (i_head.op == OP_RX_LAST) begin
                    n_status = ST_OK;
                    done_res = 1'b1;
                    stop_set = 1'b1;
                end else begin
                    ack_ctl = ack_choice(n_byte_index, r_transfer_length);
                end
            end
            OP_UNKNOWN: begin
                irq_clear = 1'b1;
                start_ctl = CTL_CLR;
                ack_ctl   = CTL_SET;
                n_status  = ST_ERR;
                done_res  = 1'b1;
            end
            default: begin
                n_byte_index = r_byte_index;
            end
        endcase
    end

    assign mem_we = o_pop && wr_req && in_buffer(wr_pos);
    assign mem_re = o_pop && rd_req;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_pos[AW-1:0]] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_start_ctl   <= start_ctl;
            r_stop_set    <= stop_set;
            r_ack_ctl     <= ack_ctl;
            r_irq_clear   <= irq_clear;
            r_tx_valid    <= tx_valid;
            r_tx_from_mem <= tx_from_mem;
            r_tx_byte     <= tx_byte;
            r_rx_valid    <= rx_valid;
            r_rx_byte     <= rx_byte;
            r_rx_index    <= rx_index;
            r_done_res    <= done_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_byte_index      <= 8'd0;
            r_status          <= ST_OK;
            r_target_address  <= 7'd0;
            r_read_not_write  <= 1'b0;
            r_transfer_length <= 8'd0;
        end else begin
            if (o_pop) begin
                r_out_valid  <= 1'b1;
                r_byte_index <= n_byte_index;
                r_status     <= n_status;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_TARGET_ADDRESS:  r_target_address  <= i_cfg.data[6:0];
                    REG_READ_NOT_WRITE:  r_read_not_write  <= i_cfg.data[0];
                    REG_TRANSFER_LENGTH: r_transfer_length <= i_cfg.data;
                    default:             r_transfer_length <= r_transfer_length;
                endcase
            end
        end
    end

    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.start_ctl   = r_start_ctl;
    assign o_out.stop_set    = r_stop_set;
    assign o_out.ack_ctl     = r_ack_ctl;
    assign o_out.irq_clear   = r_irq_clear;
    assign o_out.tx_valid    = r_tx_valid;
    assign o_out.tx_byte     = r_tx_from_mem ? r_rd_data : r_tx_byte;
    assign o_out.rx_valid    = r_rx_valid;
    assign o_out.rx_byte     = r_rx_byte;
    assign o_out.rx_index    = r_rx_index;
    assign o_out.done_res    = r_done_res;
    assign o_out.xfer_status = r_status;

endmodule
